@@ sv/ipv4_fragment_header_gen_assert.svh @@
// Assertion macros shared by the checker of the IPv4 fragment header generator.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef IPV4_FRAGMENT_HEADER_GEN_ASSERT_SVH
`define IPV4_FRAGMENT_HEADER_GEN_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IFHG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IFHG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ifhg_pkg.sv @@
// Shared constants and types of the IPv4 fragment header generator.
// No dependencies; used by the checksum unit and the top level.
package ifhg_pkg;

  localparam logic [13:0] IP_HDR_BYTES = 14'd20;
  localparam logic [13:0] MTU_MIN      = 14'd1064;
  localparam logic [13:0] MTU_MAX      = 14'd9000;
  localparam logic [13:0] MTU_RESET    = 14'd1500;
  localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [15:0] FLAG_DF      = 16'h4000;
  localparam logic [15:0] FLAG_MF      = 16'h2000;

  // Checksum accumulator width: nine 16-bit words fit in 20 bits.
  localparam int unsigned ACC_W = 20;

  localparam logic [1:0] ALU_HOLD = 2'd0;
  localparam logic [1:0] ALU_LOAD = 2'd1;
  localparam logic [1:0] ALU_ADD  = 2'd2;
  localparam logic [1:0] ALU_FOLD = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       use_base;
  } alu_ctl_t;

endpackage

@@ sv/ifhg_csum_alu.sv @@
// Shared ones-complement checksum adder with its accumulator register.
// Depends on ifhg_pkg for the operation codes and the control struct.
module ifhg_csum_alu (
  input  logic                          clk,
  input  ifhg_pkg::alu_ctl_t            ctl,
  input  logic [15:0]                   word,
  input  logic [ifhg_pkg::ACC_W-1:0]    base,
  output logic [ifhg_pkg::ACC_W-1:0]    sum
);

  logic [ifhg_pkg::ACC_W-1:0] acc_r;
  logic [ifhg_pkg::ACC_W-1:0] acc_nxt;
  logic [ifhg_pkg::ACC_W-1:0] opa;
  logic [ifhg_pkg::ACC_W-1:0] opb;

  always_comb begin
    unique case (ctl.op)
      ifhg_pkg::ALU_FOLD: begin
        // End-around carry: low half plus the carries above it.
        opa = {{(ifhg_pkg::ACC_W-16){1'b0}}, acc_r[15:0]};
        opb = {16'd0, acc_r[ifhg_pkg::ACC_W-1:16]};
      end
      ifhg_pkg::ALU_LOAD: begin
        opa = '0;
        opb = {{(ifhg_pkg::ACC_W-16){1'b0}}, word};
      end
      default: begin
        opa = ctl.use_base ? base : acc_r;
        opb = {{(ifhg_pkg::ACC_W-16){1'b0}}, word};
      end
    endcase
    sum     = opa + opb;
    acc_nxt = (ctl.op == ifhg_pkg::ALU_HOLD) ? acc_r : sum;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

@@ sv/ipv4_fragment_header_gen.sv @@
// IPv4 fragment header generator. A request is taken only while in_stall is low; it then
// sums the fixed header words once, then steps each fragment through the single shared
// checksum adder (add total length, add flags/offset, two carry folds), and takes no new
// request until its last result has been loaded into the output register.
// A zero-length request yields nothing; a DF request that does not fit yields one error
// result. The mtu value in use is saturated to 1064..9000.
// Depends on ifhg_pkg and ifhg_csum_alu.
module ipv4_fragment_header_gen (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_mtu,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_payload_len,
  input  logic [15:0] in_packet_id,
  input  logic [7:0]  in_protocol,
  input  logic [7:0]  in_time_to_live,
  input  logic        in_dont_fragment,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_total_length,
  output logic [15:0] out_flags_offset,
  output logic [15:0] out_header_checksum,
  output logic [15:0] out_payload_start,
  output logic [13:0] out_fragment_len,
  output logic [15:0] out_frag_id,
  output logic        out_too_long,
  output logic        out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BASE = 3'd1;
  localparam logic [2:0] ST_F0   = 3'd2;
  localparam logic [2:0] ST_F1   = 3'd3;
  localparam logic [2:0] ST_F2   = 3'd4;
  localparam logic [2:0] ST_F3   = 3'd5;
  localparam logic [2:0] ST_ERR  = 3'd6;

  localparam logic [2:0] BASE_LAST = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [13:0] mtu_r;

  logic [13:0] room_r, room_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] id_r;
  logic [7:0]  proto_r;
  logic [7:0]  ttl_r;
  logic        df_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [ifhg_pkg::ACC_W-1:0] base_r;

  logic        out_valid_r;
  logic [13:0] out_total_length_r;
  logic [15:0] out_flags_offset_r;
  logic [15:0] out_header_checksum_r;
  logic [15:0] out_payload_start_r;
  logic [13:0] out_fragment_len_r;
  logic [15:0] out_frag_id_r;
  logic        out_too_long_r;
  logic        out_last_r;

  logic        in_xfer;
  logic        out_free;
  logic        load_frag;
  logic        load_err;
  logic [13:0] mtu_sat;
  logic [13:0] room_now;
  logic [13:0] chunk;
  logic        more;
  logic [13:0] flen;
  logic [13:0] tot;
  logic [15:0] fo;
  logic [15:0] alu_word;
  logic [ifhg_pkg::ACC_W-1:0] alu_sum;
  ifhg_pkg::alu_ctl_t alu_ctl;

  // Neither channel takes a transfer while reset is held.
  assign cfg_ready = rst_n;
  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (mtu_r < ifhg_pkg::MTU_MIN) begin
      mtu_sat = ifhg_pkg::MTU_MIN;
    end else if (mtu_r > ifhg_pkg::MTU_MAX) begin
      mtu_sat = ifhg_pkg::MTU_MAX;
    end else begin
      mtu_sat = mtu_r;
    end
    room_now = mtu_sat - ifhg_pkg::IP_HDR_BYTES;
  end

  // Fragment fields of the fragment in progress.
  always_comb begin
    chunk = {room_r[13:3], 3'b000};
    more  = (remaining_r > {2'b00, room_r});
    flen  = more ? chunk : remaining_r[13:0];
    tot   = ifhg_pkg::IP_HDR_BYTES + flen;
    if (df_r) begin
      fo = ifhg_pkg::FLAG_DF;
    end else begin
      fo = (more ? ifhg_pkg::FLAG_MF : 16'd0) | {3'b000, start_r[15:3]};
    end
  end

  always_comb begin
    alu_ctl.op       = ifhg_pkg::ALU_HOLD;
    alu_ctl.use_base = 1'b0;
    alu_word         = 16'd0;
    unique case (state_r)
      ST_IDLE: begin
        alu_ctl.op = ifhg_pkg::ALU_LOAD;
        alu_word   = ifhg_pkg::VER_IHL_TOS;
      end
      ST_BASE: begin
        alu_ctl.op = ifhg_pkg::ALU_ADD;
        unique case (step_r)
          3'd0:    alu_word = id_r;
          3'd1:    alu_word = {ttl_r, proto_r};
          3'd2:    alu_word = src_r[31:16];
          3'd3:    alu_word = src_r[15:0];
          3'd4:    alu_word = dst_r[31:16];
          default: alu_word = dst_r[15:0];
        endcase
      end
      ST_F0: begin
        alu_ctl.op       = ifhg_pkg::ALU_ADD;
        alu_ctl.use_base = 1'b1;
        alu_word         = {2'b00, tot};
      end
      ST_F1: begin
        alu_ctl.op = ifhg_pkg::ALU_ADD;
        alu_word   = fo;
      end
      ST_F2, ST_F3: begin
        // The second fold settles, so repeating it while stalled is harmless.
        alu_ctl.op = ifhg_pkg::ALU_FOLD;
      end
      default: begin
        alu_ctl.op = ifhg_pkg::ALU_HOLD;
      end
    endcase
  end

  ifhg_csum_alu u_alu (
    .clk  (clk),
    .ctl  (alu_ctl),
    .word (alu_word),
    .base (base_r),
    .sum  (alu_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    room_nxt      = room_r;
    remaining_nxt = remaining_r;
    start_nxt     = start_r;
    load_frag     = 1'b0;
    load_err      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          room_nxt      = room_now;
          remaining_nxt = in_payload_len;
          start_nxt     = 16'd0;
          step_nxt      = 3'd0;
          if (in_payload_len == 16'd0) begin
            state_nxt = ST_IDLE;
          end else if (in_dont_fragment && (in_payload_len > {2'b00, room_now})) begin
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        step_nxt = step_r + 3'd1;
        if (step_r == BASE_LAST) begin
          state_nxt = ST_F0;
        end
      end
      ST_F0: state_nxt = ST_F1;
      ST_F1: state_nxt = ST_F2;
      ST_F2: state_nxt = ST_F3;
      ST_F3: begin
        if (out_free) begin
          load_frag     = 1'b1;
          start_nxt     = start_r + {2'b00, flen};
          remaining_nxt = remaining_r - {2'b00, flen};
          state_nxt     = more ? ST_F0 : ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load_err  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      mtu_r       <= ifhg_pkg::MTU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        mtu_r <= cfg_mtu;
      end
      if (load_frag || load_err) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    room_r      <= room_nxt;
    remaining_r <= remaining_nxt;
    start_r     <= start_nxt;
    if (in_xfer) begin
      id_r    <= in_packet_id;
      proto_r <= in_protocol;
      ttl_r   <= in_time_to_live;
      df_r    <= in_dont_fragment;
      src_r   <= in_src_addr;
      dst_r   <= in_dst_addr;
    end
    if (state_r == ST_BASE && step_r == BASE_LAST) begin
      base_r <= alu_sum;
    end
    if (load_frag) begin
      out_total_length_r    <= tot;
      out_flags_offset_r    <= fo;
      out_header_checksum_r <= ~alu_sum[15:0];
      out_payload_start_r   <= start_r;
      out_fragment_len_r    <= flen;
      out_frag_id_r         <= id_r;
      out_too_long_r        <= 1'b0;
      out_last_r            <= !more;
    end else if (load_err) begin
      out_total_length_r    <= 14'd0;
      out_flags_offset_r    <= 16'd0;
      out_header_checksum_r <= 16'd0;
      out_payload_start_r   <= 16'd0;
      out_fragment_len_r    <= 14'd0;
      out_frag_id_r         <= 16'd0;
      out_too_long_r        <= 1'b1;
      out_last_r            <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_total_length    = out_total_length_r;
  assign out_flags_offset    = out_flags_offset_r;
  assign out_header_checksum = out_header_checksum_r;
  assign out_payload_start   = out_payload_start_r;
  assign out_fragment_len    = out_fragment_len_r;
  assign out_frag_id         = out_frag_id_r;
  assign out_too_long        = out_too_long_r;
  assign out_last            = out_last_r;

endmodule

@@ sv/ifhg_checker.sv @@
// Port-level checker for the IPv4 fragment header generator, bound to the top level.
// Depends on ipv4_fragment_header_gen_assert.svh for the assertion macros.
`include "ipv4_fragment_header_gen_assert.svh"

module ifhg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_total_length,
  input logic [15:0] out_flags_offset,
  input logic [15:0] out_header_checksum,
  input logic [13:0] out_fragment_len,
  input logic        out_too_long,
  input logic        out_last
);

  // A stalled result must still be offered in the next cycle, with its checksum and last flag unchanged.
  `IFHG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_header_checksum) && $stable(out_last), "stalled result changed")

  // An error result closes its request and carries no header.
  `IFHG_ASSERT_NOW(a_err_shape, out_valid && out_too_long, out_last && (out_total_length == 14'd0) && (out_flags_offset == 16'd0), "malformed error result")

  // A fragment's total length is always its payload plus the 20-byte header.
  `IFHG_ASSERT_NOW(a_tot_len, out_valid && !out_too_long, out_total_length == (out_fragment_len + 14'd20), "total length mismatch")

  // A fragment with more to follow cannot be flagged as the last one.
  `IFHG_ASSERT_NOW(a_mf_last, out_valid && !out_too_long && out_flags_offset[13], !out_last, "MF set on last fragment")

  // A request that is offered and stalled stays offered until its transfer.
  `IFHG_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid, "input request withdrawn while stalled")

endmodule

bind ipv4_fragment_header_gen ifhg_checker u_ifhg_checker (.*);
